// ===== hdl/bcpe_pkg.sv =====
// Shared constants and types for the Bezier curve point evaluator.
package bcpe_pkg;

   localparam int COORD_BITS = 16;
   localparam int TIME_BITS  = 16;
   localparam int DUR_BITS   = 16;
   localparam int T_FRAC     = 16;
   localparam int T_BITS     = T_FRAC + 1;
   localparam int SQ_BITS    = 2 * T_FRAC + 1;
   localparam int W_FRAC     = 3 * T_FRAC;
   localparam int W_BITS     = W_FRAC + 1;
   localparam int PROD_BITS  = W_BITS + 1 + COORD_BITS;
   localparam int SUM_BITS   = PROD_BITS + 2;
   localparam int POINT_BITS = 3 * COORD_BITS;
   localparam int NUM_POINTS = 4;
   localparam int NUM_AXES   = 3;
   localparam int REQ_BITS   = ((TIME_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = ((POINT_BITS + 7) / 8) * 8;
   localparam int CSR_BITS   = 3;
   localparam int DIV_STAGES = T_FRAC + 1;

   localparam logic [T_BITS-1:0] T_ONE = T_BITS'(1) << T_FRAC;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_DEGREE   = 3'd0,
      CSR_DURATION = 3'd1,
      CSR_POINT_0  = 3'd2,
      CSR_POINT_1  = 3'd3,
      CSR_POINT_2  = 3'd4,
      CSR_POINT_3  = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      DEG_LINEAR    = 2'd0,
      DEG_QUADRATIC = 2'd1,
      DEG_CUBIC     = 2'd2
   } degree_type;

   // quotient and clamp flags leaving the divider
   typedef struct packed {
      logic [T_FRAC-1:0] quot;
      logic              at_start;
      logic              at_end;
   } div_out_type;

endpackage

// ===== hdl/bcpe_div.sv =====
// Pipelined restoring divider that maps sample time to the curve parameter.
module bcpe_div (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [bcpe_pkg::TIME_BITS-1:0]   in_time,
   input  logic        [bcpe_pkg::DUR_BITS-1:0]    duration,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output bcpe_pkg::div_out_type                   out_data
);
   import bcpe_pkg::*;

   localparam int CMP_BITS = (TIME_BITS - 1 > DUR_BITS) ? TIME_BITS - 1 : DUR_BITS;

   logic                 v_ff   [DIV_STAGES];
   logic [DUR_BITS-1:0]  rem_ff [DIV_STAGES];
   logic [T_FRAC-1:0]    q_ff   [DIV_STAGES];
   logic                 z_ff   [DIV_STAGES];
   logic                 o_ff   [DIV_STAGES];
   logic [DUR_BITS-1:0]  rem_in [DIV_STAGES];
   logic [T_FRAC-1:0]    q_in   [DIV_STAGES];
   logic                 rdy    [DIV_STAGES];

   logic [DUR_BITS-1:0]  dd;
   logic [DUR_BITS-1:0]  half;
   logic [CMP_BITS-1:0]  mag;
   logic                 start0;
   logic                 end0;

   always_comb begin
      dd   = (duration == '0) ? DUR_BITS'(1) : duration;
      half = dd >> 1;
      mag  = CMP_BITS'(in_time[TIME_BITS-2:0]);
      start0 = in_time[TIME_BITS-1] || (in_time == '0);
      end0   = !start0 && (mag >= CMP_BITS'(dd));
   end

   // one quotient bit per stage after the first; the remainder stays below the duration unless clamped
   always_comb begin
      logic [DUR_BITS:0] r2;
      rem_in[0] = mag[DUR_BITS-1:0];
      q_in[0]   = '0;
      for (int k = 1; k < DIV_STAGES; k++) begin
         r2 = {rem_ff[k-1], half[T_FRAC-k]};
         if (r2 >= {1'b0, dd}) begin
            r2        = r2 - {1'b0, dd};
            q_in[k]   = {q_ff[k-1][T_FRAC-2:0], 1'b1};
         end else begin
            q_in[k]   = {q_ff[k-1][T_FRAC-2:0], 1'b0};
         end
         rem_in[k] = r2[DUR_BITS-1:0];
      end
   end

   always_comb begin
      rdy[DIV_STAGES-1] = !v_ff[DIV_STAGES-1] || out_ready;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < DIV_STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && in_valid) begin
         rem_ff[0] <= rem_in[0];
         q_ff[0]   <= q_in[0];
         z_ff[0]   <= start0;
         o_ff[0]   <= end0;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         if (rdy[k] && v_ff[k-1]) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            z_ff[k]   <= z_ff[k-1];
            o_ff[k]   <= o_ff[k-1];
         end
      end
   end

   assign in_ready          = rdy[0];
   assign out_valid         = v_ff[DIV_STAGES-1];
   assign out_data.quot     = q_ff[DIV_STAGES-1];
   assign out_data.at_start = z_ff[DIV_STAGES-1];
   assign out_data.at_end   = o_ff[DIV_STAGES-1];

endmodule

// ===== hdl/bezier_curve_point_evaluator.sv =====
// Top level: Bezier trajectory point evaluator with configuration registers.
// The pipeline has 17 divider stages and 6 blend stages.
// Throughput: one request per cycle; each stage holds when the one after it is full
// and stalled, so bubbles close up and requests keep entering behind a held result.
// The rate is set by the one-bit-per-stage divider and the blend multipliers.
// Synchronous active-high reset empties the pipeline and restores degree cubic,
// duration one and all control points zero.
module bezier_curve_point_evaluator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bcpe_pkg::REQ_BITS-1:0]     req_tdata,   // [15:0] sample_time
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bcpe_pkg::RSP_BITS-1:0]     rsp_tdata,   // pos_x, pos_y, pos_z
   input  logic                              csr_we,
   input  logic [bcpe_pkg::CSR_BITS-1:0]     csr_addr,
   input  logic [bcpe_pkg::POINT_BITS-1:0]   csr_wdata
);
   import bcpe_pkg::*;

   // configuration
   logic [1:0]            degree_ff;
   logic [DUR_BITS-1:0]   duration_ff;
   logic [POINT_BITS-1:0] point_ff [NUM_POINTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff   <= DEG_CUBIC;
         duration_ff <= DUR_BITS'(1);
         for (int i = 0; i < NUM_POINTS; i++) begin
            point_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_addr)
            CSR_DEGREE:   degree_ff   <= csr_wdata[1:0];
            CSR_DURATION: duration_ff <= csr_wdata[DUR_BITS-1:0];
            CSR_POINT_0:  point_ff[0] <= csr_wdata;
            CSR_POINT_1:  point_ff[1] <= csr_wdata;
            CSR_POINT_2:  point_ff[2] <= csr_wdata;
            CSR_POINT_3:  point_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // divider
   logic        dv_valid;
   logic        dv_ready;
   div_out_type dv_data;

   bcpe_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_time   (req_tdata[TIME_BITS-1:0]),
      .duration  (duration_ff),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_data  (dv_data)
   );

   // blend stages A..F
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff;
   logic ra, rb, rc, rd, re, rf;

   assign rf = !vf_ff || rsp_tready;
   assign re = !ve_ff || rf;
   assign rd = !vd_ff || re;
   assign rc = !vc_ff || rd;
   assign rb = !vb_ff || rc;
   assign ra = !va_ff || rb;
   assign dv_ready = ra;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else begin
         if (ra) va_ff <= dv_valid;
         if (rb) vb_ff <= va_ff;
         if (rc) vc_ff <= vb_ff;
         if (rd) vd_ff <= vc_ff;
         if (re) ve_ff <= vd_ff;
         if (rf) vf_ff <= ve_ff;
      end
   end

   // A: clamped curve parameter
   logic [T_BITS-1:0] ta_ff, ta_in;
   always_comb begin
      if (dv_data.at_start)    ta_in = '0;
      else if (dv_data.at_end) ta_in = T_ONE;
      else                     ta_in = {1'b0, dv_data.quot};
   end
   always_ff @(posedge clock) begin
      if (ra && dv_valid) ta_ff <= ta_in;
   end

   // B: squares and cross term
   logic [T_BITS-1:0]  tb_ff, ub_ff, ua;
   logic [SQ_BITS-1:0] t2b_ff, u2b_ff, utb_ff;
   logic [2*T_BITS-1:0] t2p, u2p, utp;
   assign ua  = T_ONE - ta_ff;
   assign t2p = ta_ff * ta_ff;
   assign u2p = ua * ua;
   assign utp = ua * ta_ff;
   always_ff @(posedge clock) begin
      if (rb && va_ff) begin
         tb_ff  <= ta_ff;
         ub_ff  <= ua;
         t2b_ff <= t2p[SQ_BITS-1:0];
         u2b_ff <= u2p[SQ_BITS-1:0];
         utb_ff <= utp[SQ_BITS-1:0];
      end
   end

   // C: cubic terms
   logic [T_BITS-1:0]  tc_ff, uc_ff;
   logic [SQ_BITS-1:0] t2c_ff, u2c_ff, utc_ff;
   logic [W_BITS-1:0]  t3c_ff, u3c_ff, u2tc_ff, ut2c_ff;
   logic [SQ_BITS+T_BITS-1:0] t3p, u3p, u2tp, ut2p;
   assign t3p  = t2b_ff * tb_ff;
   assign u3p  = u2b_ff * ub_ff;
   assign u2tp = u2b_ff * tb_ff;
   assign ut2p = utb_ff * tb_ff;
   always_ff @(posedge clock) begin
      if (rc && vb_ff) begin
         tc_ff   <= tb_ff;
         uc_ff   <= ub_ff;
         t2c_ff  <= t2b_ff;
         u2c_ff  <= u2b_ff;
         utc_ff  <= utb_ff;
         t3c_ff  <= t3p[W_BITS-1:0];
         u3c_ff  <= u3p[W_BITS-1:0];
         u2tc_ff <= u2tp[W_BITS-1:0];
         ut2c_ff <= ut2p[W_BITS-1:0];
      end
   end

   // D: Bernstein weights for the selected degree, all at 48 fraction bits
   logic [W_BITS-1:0] wd_ff [NUM_POINTS];
   logic [W_BITS-1:0] wd_in [NUM_POINTS];
   always_comb begin
      case (degree_ff)
         DEG_LINEAR: begin
            wd_in[0] = W_BITS'(uc_ff) << (2 * T_FRAC);
            wd_in[1] = W_BITS'(tc_ff) << (2 * T_FRAC);
            wd_in[2] = '0;
            wd_in[3] = '0;
         end
         DEG_QUADRATIC: begin
            wd_in[0] = W_BITS'(u2c_ff) << T_FRAC;
            wd_in[1] = W_BITS'(utc_ff) << (T_FRAC + 1);
            wd_in[2] = W_BITS'(t2c_ff) << T_FRAC;
            wd_in[3] = '0;
         end
         default: begin
            wd_in[0] = u3c_ff;
            wd_in[1] = u2tc_ff + (u2tc_ff << 1);
            wd_in[2] = ut2c_ff + (ut2c_ff << 1);
            wd_in[3] = t3c_ff;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (rd && vc_ff) begin
         for (int i = 0; i < NUM_POINTS; i++) begin
            wd_ff[i] <= wd_in[i];
         end
      end
   end

   // E: weighted coordinates
   logic signed [PROD_BITS-1:0] pe_ff [NUM_AXES][NUM_POINTS];
   always_ff @(posedge clock) begin
      if (re && vd_ff) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
               pe_ff[a][i] <= $signed({1'b0, wd_ff[i]})
                            * $signed(point_ff[i][a*COORD_BITS +: COORD_BITS]);
            end
         end
      end
   end

   // F: sum and round half up to the coordinate format
   logic [COORD_BITS-1:0] pos_ff [NUM_AXES];
   logic [COORD_BITS-1:0] pos_in [NUM_AXES];
   always_comb begin
      logic signed [SUM_BITS-1:0] acc;
      for (int a = 0; a < NUM_AXES; a++) begin
         acc = SUM_BITS'(1) <<< (W_FRAC - 1);
         for (int i = 0; i < NUM_POINTS; i++) begin
            acc = acc + SUM_BITS'(pe_ff[a][i]);
         end
         pos_in[a] = acc[W_FRAC +: COORD_BITS];
      end
   end
   always_ff @(posedge clock) begin
      if (rf && ve_ff) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            pos_ff[a] <= pos_in[a];
         end
      end
   end

   assign rsp_tvalid = vf_ff;
   assign rsp_tdata  = RSP_BITS'({pos_ff[2], pos_ff[1], pos_ff[0]});

   // checks
   logic [W_BITS+1:0] wsum;
   assign wsum = (W_BITS+2)'(wd_ff[0]) + (W_BITS+2)'(wd_ff[1])
               + (W_BITS+2)'(wd_ff[2]) + (W_BITS+2)'(wd_ff[3]);

   weights_convex: assert property (@(posedge clock) disable iff (reset)
      vd_ff |-> (wsum == ((W_BITS+2)'(1) << W_FRAC)))
      else $error("blend weights do not sum to one");

   clamp_exclusive: assert property (@(posedge clock) disable iff (reset)
      dv_valid |-> !(dv_data.at_start && dv_data.at_end))
      else $error("both clamp flags set");

   param_held: assert property (@(posedge clock) disable iff (reset)
      (va_ff && !rb) |=> (va_ff && $stable(ta_ff)))
      else $error("curve parameter lost during stall");

endmodule
